// ===== hdl/coin_measure_sort_sequencer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Coin measure sort sequencer assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef COIN_MEASURE_SORT_SEQUENCER_UNIT_DEFINES_SVH
`define COIN_MEASURE_SORT_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cmss_pkg.sv =====
// ----------------------------------------------------------------------------
// Coin measure sort sequencer package
// Types, codes and helper functions shared by the sequencer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmss_pkg;

  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_LIGHT_THRESHOLD  = 3'd0;
  localparam cfg_idx_t CFG_SETTLE_TICKS     = 3'd1;
  localparam cfg_idx_t CFG_WAIT_LIMIT       = 3'd2;
  localparam cfg_idx_t CFG_LARGE_MIN_TICKS  = 3'd3;
  localparam cfg_idx_t CFG_MEDIUM_MIN_TICKS = 3'd4;
  localparam cfg_idx_t CFG_SWING_LIMIT      = 3'd5;

  localparam cnt_t SETTLE_RESET  = 16'd500;
  localparam cnt_t TIMEOUT_RESET = 16'd6000;
  localparam cnt_t LARGE_RESET   = 16'd125;
  localparam cnt_t MEDIUM_RESET  = 16'd90;
  localparam cnt_t SWING_RESET   = 16'd10;
  localparam int   LIGHT_RESET   = 1000;

  typedef logic [1:0] class_t;
  localparam class_t CLASS_LARGE  = 2'd0;
  localparam class_t CLASS_MEDIUM = 2'd1;
  localparam class_t CLASS_SMALL  = 2'd2;
  localparam class_t CLASS_NONE   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_NORMAL  = 2'd0;
  localparam status_t STATUS_TIMEOUT = 2'd1;
  localparam status_t STATUS_SWING   = 2'd2;

  typedef logic [7:0] angle_t;
  localparam angle_t SLIDE_LARGE  = 8'd4;
  localparam angle_t SLIDE_MEDIUM = 8'd32;
  localparam angle_t SLIDE_SMALL  = 8'd60;
  localparam angle_t SLIDE_NONE   = 8'd88;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_SETTLE  = 4'b0010,
    PH_WAIT    = 4'b0100,
    PH_OVERLAP = 4'b1000
  } phase_t;

  typedef struct packed {
    cnt_t settle_ticks;
    cnt_t wait_limit;
    cnt_t large_min_ticks;
    cnt_t medium_min_ticks;
    cnt_t swing_limit;
  } cfg_t;

  typedef struct packed {
    class_t  coin_class;
    angle_t  slide_position;
    cnt_t    overlap_ticks;
    cnt_t    channel_ticks;
    status_t measure_status;
  } res_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == {CNT_W{1'b1}}) ? v : v + cnt_t'(1);
  endfunction

  function automatic angle_t slide_of(class_t c);
    angle_t a;
    case (c)
      CLASS_LARGE:  a = SLIDE_LARGE;
      CLASS_MEDIUM: a = SLIDE_MEDIUM;
      CLASS_SMALL:  a = SLIDE_SMALL;
      default:      a = SLIDE_NONE;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cmss_cfg.sv =====
// ----------------------------------------------------------------------------
// Coin measure sort sequencer configuration registers
// Holds the threshold and tick limits written through the configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmss_cfg #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire cmss_pkg::cfg_idx_t   wr_index,
  input  wire cmss_pkg::cfg_data_t  wr_data,
  output logic [SAMPLE_BITS-1:0]    light_threshold,
  output cmss_pkg::cfg_t            cfg
);
  import cmss_pkg::*;

  logic [SAMPLE_BITS-1:0] light_r;
  cfg_t                   cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r                <= SAMPLE_BITS'(LIGHT_RESET);
      cfg_r.settle_ticks     <= SETTLE_RESET;
      cfg_r.wait_limit       <= TIMEOUT_RESET;
      cfg_r.large_min_ticks  <= LARGE_RESET;
      cfg_r.medium_min_ticks <= MEDIUM_RESET;
      cfg_r.swing_limit      <= SWING_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_LIGHT_THRESHOLD:  light_r                <= wr_data[SAMPLE_BITS-1:0];
        CFG_SETTLE_TICKS:     cfg_r.settle_ticks     <= wr_data;
        CFG_WAIT_LIMIT:       cfg_r.wait_limit       <= wr_data;
        CFG_LARGE_MIN_TICKS:  cfg_r.large_min_ticks  <= wr_data;
        CFG_MEDIUM_MIN_TICKS: cfg_r.medium_min_ticks <= wr_data;
        CFG_SWING_LIMIT:      cfg_r.swing_limit      <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign light_threshold = light_r;
  assign cfg             = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/cmss_seq.sv =====
// ----------------------------------------------------------------------------
// Coin measure sort sequencer phase logic
// Per-tick phase machine with settle, channel and overlap counters, the
// weight peak, and classification of the finished measurement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmss_seq #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic [SAMPLE_BITS-1:0] light_level,
  input  wire logic [SAMPLE_BITS-1:0] weight_sample,
  input  wire logic                   overlap_seen,
  input  wire logic [SAMPLE_BITS-1:0] light_threshold,
  input  wire cmss_pkg::cfg_t         cfg,
  output logic                        emit,
  output cmss_pkg::res_t              res,
  output logic [SAMPLE_BITS-1:0]      peak
);
  import cmss_pkg::*;

  phase_t                 phase_r, phase_nxt;
  cnt_t                   settle_r, settle_nxt;
  cnt_t                   chan_r, chan_nxt;
  cnt_t                   ovl_r, ovl_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  status_t                status;
  class_t                 cls;

  always_comb begin
    phase_nxt  = phase_r;
    settle_nxt = settle_r;
    chan_nxt   = chan_r;
    ovl_nxt    = ovl_r;
    peak_nxt   = peak_r;
    emit       = 1'b0;
    status     = STATUS_NORMAL;
    case (phase_r)
      PH_SETTLE: begin
        settle_nxt = sat_inc(settle_r);
        if (settle_nxt >= cfg.settle_ticks) begin
          phase_nxt = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (weight_sample > peak_r) begin
          peak_nxt = weight_sample;
        end
        chan_nxt = sat_inc(chan_r);
        if (overlap_seen) begin
          phase_nxt = PH_OVERLAP;
        end else if (chan_nxt >= cfg.wait_limit) begin
          emit      = 1'b1;
          status    = STATUS_TIMEOUT;
          phase_nxt = PH_IDLE;
        end
      end
      PH_OVERLAP: begin
        ovl_nxt = sat_inc(ovl_r);
        if (!overlap_seen) begin
          emit      = 1'b1;
          status    = (ovl_nxt <= cfg.swing_limit) ? STATUS_SWING : STATUS_NORMAL;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (light_level < light_threshold) begin
          settle_nxt = '0;
          chan_nxt   = '0;
          ovl_nxt    = '0;
          peak_nxt   = '0;
          phase_nxt  = (cfg.settle_ticks == '0) ? PH_WAIT : PH_SETTLE;
        end
      end
    endcase
  end

  always_comb begin
    if (ovl_nxt > cfg.large_min_ticks) begin
      cls = CLASS_LARGE;
    end else if (ovl_nxt > cfg.medium_min_ticks) begin
      cls = CLASS_MEDIUM;
    end else if (ovl_nxt != '0) begin
      cls = CLASS_SMALL;
    end else begin
      cls = CLASS_NONE;
    end
  end

  always_comb begin
    res.coin_class     = cls;
    res.slide_position = slide_of(cls);
    res.overlap_ticks  = ovl_nxt;
    res.channel_ticks  = chan_nxt;
    res.measure_status = status;
  end

  assign peak = peak_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      settle_r <= '0;
      chan_r   <= '0;
      ovl_r    <= '0;
      peak_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      settle_r <= settle_nxt;
      chan_r   <= chan_nxt;
      ovl_r    <= ovl_nxt;
      peak_r   <= peak_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/coin_measure_sort_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// Coin measure sort sequencer unit
// Takes one sensor tick per request, runs the coin measurement sequence and
// delivers one classification request per coin.
//
//   Channel  Direction  Contents
//   in_      input      light level, weight sample, overlap bit of one tick
//   out_     output     class, slide angle, peak weight, durations, status
//   cfg_     input      register index and write data
//
// Each tick is held in the input register and, when it ends a coin, its
// result is then captured in the output register. One tick is taken every
// cycle while the input register is not stalled.
// The input register stalls only while a result waits for out_ready.
// Synchronous reset clears the phase, counters and both valid flags and
// restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module coin_measure_sort_sequencer_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_light_level,
  input  wire logic [SAMPLE_BITS-1:0] in_weight_sample,
  input  wire logic                   in_overlap_seen,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output cmss_pkg::class_t            out_coin_class,
  output cmss_pkg::angle_t            out_slide_position,
  output logic [SAMPLE_BITS-1:0]      out_peak_weight,
  output cmss_pkg::cnt_t              out_overlap_ticks,
  output cmss_pkg::cnt_t              out_channel_ticks,
  output cmss_pkg::status_t           out_measure_status,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire cmss_pkg::cfg_idx_t     cfg_index,
  input  wire cmss_pkg::cfg_data_t    cfg_data
);
  import cmss_pkg::*;

  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_light_r;
  logic [SAMPLE_BITS-1:0] s1_weight_r;
  logic                   s1_ovl_r;
  logic                   advance;
  logic                   emit;
  res_t                   res;
  logic [SAMPLE_BITS-1:0] peak;
  logic [SAMPLE_BITS-1:0] light_threshold;
  cfg_t                   cfg;
  logic                   out_valid_r;
  res_t                   out_res_r;
  logic [SAMPLE_BITS-1:0] out_peak_r;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;

  cmss_cfg #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr_en           (cfg_valid && cfg_ready),
    .wr_index        (cfg_index),
    .wr_data         (cfg_data),
    .light_threshold (light_threshold),
    .cfg             (cfg)
  );

  cmss_seq #(.SAMPLE_BITS(SAMPLE_BITS)) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .light_level     (s1_light_r),
    .weight_sample   (s1_weight_r),
    .overlap_seen    (s1_ovl_r),
    .light_threshold (light_threshold),
    .cfg             (cfg),
    .emit            (emit),
    .res             (res),
    .peak            (peak)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_light_r  <= in_light_level;
      s1_weight_r <= in_weight_sample;
      s1_ovl_r    <= in_overlap_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r  <= res;
      out_peak_r <= peak;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_coin_class     = out_res_r.coin_class;
  assign out_slide_position = out_res_r.slide_position;
  assign out_peak_weight    = out_peak_r;
  assign out_overlap_ticks  = out_res_r.overlap_ticks;
  assign out_channel_ticks  = out_res_r.channel_ticks;
  assign out_measure_status = out_res_r.measure_status;

endmodule

`default_nettype wire

// ===== hdl/cmss_checker.sv =====
// ----------------------------------------------------------------------------
// Coin measure sort sequencer checker
// Port-level assertions on result consistency and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "coin_measure_sort_sequencer_unit_defines.svh"

module cmss_props #(
  parameter int SAMPLE_BITS = 12
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire cmss_pkg::class_t       out_coin_class,
  input wire cmss_pkg::angle_t       out_slide_position,
  input wire logic [SAMPLE_BITS-1:0] out_peak_weight,
  input wire cmss_pkg::cnt_t         out_overlap_ticks,
  input wire cmss_pkg::cnt_t         out_channel_ticks,
  input wire cmss_pkg::status_t      out_measure_status
);
  import cmss_pkg::*;

  `CMSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_peak_weight) && $stable(out_overlap_ticks)
    && $stable(out_channel_ticks) && $stable(out_measure_status),
    "Stalled result request changed.")

  `CMSS_ASSERT_NOW(a_slide_match, clk, rst_n, out_valid,
    (out_coin_class == CLASS_LARGE && out_slide_position == SLIDE_LARGE)
    || (out_coin_class == CLASS_MEDIUM && out_slide_position == SLIDE_MEDIUM)
    || (out_coin_class == CLASS_SMALL && out_slide_position == SLIDE_SMALL)
    || (out_coin_class == CLASS_NONE && out_slide_position == SLIDE_NONE),
    "Slide position does not match coin class.")

  `CMSS_ASSERT_NOW(a_timeout_empty, clk, rst_n,
    out_valid && out_measure_status == STATUS_TIMEOUT,
    out_overlap_ticks == '0 && out_coin_class == CLASS_NONE,
    "Timeout result carries an overlap duration.")

  `CMSS_ASSERT_NOW(a_overlap_counted, clk, rst_n,
    out_valid && out_measure_status != STATUS_TIMEOUT,
    out_overlap_ticks != '0 && out_coin_class != CLASS_NONE
    && out_channel_ticks != '0,
    "Overlap result without counted overlap or channel ticks.")

endmodule

bind coin_measure_sort_sequencer_unit cmss_props #(.SAMPLE_BITS(SAMPLE_BITS)) u_cmss_props (.*);

`default_nettype wire
